// ===== hw/rtl/art_pkg.sv =====
// Shared types, request and status codes for the address region table.
package art_pkg;

  // Default table depth
  localparam int ENTRIES_DEF = 64;

  // Request types
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] address;
    logic [31:0] region_size;
    logic [15:0] name_tag;
    logic        kernel_image;
    logic        last_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [15:0] result_tag;
    logic [63:0] offset;
    logic        last_frame;
  } rsp_t;

  // One stored region
  typedef struct packed {
    logic [63:0] base;
    logic [31:0] length;
    logic [15:0] tag;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic issue;
    logic scan_end;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic more;
    logic pend;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/art_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/art_ctrl.sv =====
// Controller state machine: accept, scan sequencing and result hand-off.
module art_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  art_pkg::stat_t stat,
  output art_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       scan_fin;

  // Scan finishes on a match, when nothing is left to read, or when none is needed
  assign scan_fin = !stat.need_scan || stat.hit || (!stat.more && !stat.pend);

  assign req_stall = (state != S_IDLE);

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && req_valid;
    cmd.issue    = (state == S_SCAN) && stat.need_scan && stat.more && !stat.hit;
    cmd.scan_end = (state == S_SCAN) && scan_fin;
    cmd.emit     = (state == S_DONE) && stat.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_fin) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/art_dp.sv =====
// Datapath: request register, region memory, scan pipeline and result register.
module art_dp #(
  parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  art_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output art_pkg::rsp_t  rsp,
  input  art_pkg::cmd_t  cmd,
  output art_pkg::stat_t stat
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  art_pkg::req_t   cur;
  art_pkg::entry_t rd_entry;
  art_pkg::entry_t wr_entry;
  art_pkg::rsp_t   res;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] rem_m1;
  logic             s1_v;
  logic             s2_v;
  logic [63:0]      s2_diff;
  logic             s2_borrow;
  logic [31:0]      s2_len;
  logic [15:0]      s2_tag;
  logic             found_q;
  logic [15:0]      tag_q;
  logic [63:0]      off_q;
  logic             is_ins;
  logic             is_look;
  logic             ins_ign;
  logic             full;
  logic             wr_en;
  logic             hit;

  assign is_ins  = (cur.req_type == art_pkg::REQ_INSERT);
  assign is_look = (cur.req_type == art_pkg::REQ_LOOKUP);
  assign ins_ign = !cur.kernel_image || (cur.name_tag == 16'd0);
  assign full    = (count == FULL_CNT);
  assign rem_m1  = rem - CNT_W'(1);

  // Region memory
  assign wr_entry = '{base: cur.address, length: cur.region_size, tag: cur.name_tag};
  assign wr_en    = cmd.emit && is_ins && !ins_ign && !full && !found_q;

  art_ram #(
    .WIDTH ($bits(art_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[IDX_W-1:0]),
    .wdata (wr_entry),
    .raddr (rem_m1[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  // Match test on the registered difference
  always_comb begin
    if (is_ins) begin
      hit = s2_v && !s2_borrow && (s2_diff == 64'd0);
    end else begin
      hit = s2_v && !s2_borrow && (s2_diff < {32'd0, s2_len});
    end
  end

  always_comb begin
    stat           = '0;
    stat.need_scan = (is_ins && !ins_ign && !full) || (is_look && (cur.address != 64'd0));
    stat.more      = (rem != '0);
    stat.pend      = s1_v || s2_v;
    stat.hit       = hit;
    stat.out_free  = !rsp_valid || !rsp_stall;
  end

  // Hold the request; walk the table from newest to oldest
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= req;
    end
    if (rst) begin
      rem  <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (cmd.accept) begin
        rem <= count;
      end else if (cmd.issue) begin
        rem <= rem_m1;
      end
      s1_v <= cmd.issue && !cmd.scan_end;
      s2_v <= s1_v && !cmd.scan_end;
    end
  end

  // Subtract stage
  always_ff @(posedge clk) begin
    {s2_borrow, s2_diff} <= {1'b0, cur.address} - {1'b0, rd_entry.base};
    s2_len               <= rd_entry.length;
    s2_tag               <= rd_entry.tag;
  end

  // Capture the first match
  always_ff @(posedge clk) begin
    if (rst) begin
      found_q <= 1'b0;
    end else if (cmd.accept) begin
      found_q <= 1'b0;
    end else if (hit) begin
      found_q <= 1'b1;
    end
    if (hit) begin
      tag_q <= s2_tag;
      off_q <= s2_diff;
    end
  end

  // Compose the result
  always_comb begin
    res = '0;
    case (cur.req_type)
      art_pkg::REQ_INSERT: begin
        if (ins_ign) begin
          res.status = art_pkg::ST_IGNORED;
        end else if (full) begin
          res.status = art_pkg::ST_FULL;
        end else if (found_q) begin
          res.status = art_pkg::ST_DUP;
        end else begin
          res.status = art_pkg::ST_DONE;
        end
      end
      art_pkg::REQ_LOOKUP: begin
        res.status     = art_pkg::ST_DONE;
        res.found      = found_q;
        res.result_tag = found_q ? tag_q : 16'd0;
        res.offset     = found_q ? off_q : cur.address;
        res.last_frame = cur.last_address;
      end
      art_pkg::REQ_CLEAR: begin
        res.status = art_pkg::ST_DONE;
      end
      default: begin
        res.status = art_pkg::ST_IGNORED;
      end
    endcase
  end

  // Fill count and output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp <= res;
    end
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.emit && (cur.req_type == art_pkg::REQ_CLEAR)) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("fill count beyond table depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count < FULL_CNT)) else $error("write into a full table");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || !rsp_stall)) else $error("result overwritten while stalled");

  a_issue_left: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (rem != '0)) else $error("read issued past the oldest entry");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && (cur.req_type == art_pkg::REQ_CLEAR)) |=> (count == '0))
    else $error("table not empty after clear");

endmodule

// ===== hw/rtl/address_region_table.sv =====
// Top level of the address region table: controller plus datapath.
//
// Requests enter on req (req_valid / req_stall) and results leave on rsp
// (rsp_valid / rsp_stall); every request gives exactly one result.
// Insert adds a region (base, size, tag) unless ignored, the table is full or
// the base is already stored. Lookup resolves an address against the stored
// regions, newest first. Clear empties the table.
// A request that needs a scan reads one stored region per cycle from the
// region memory's single read port: a miss reads every stored region before
// its result, a hit stops early. Requests that need no scan (ignored or
// dropped inserts, clear, zero-address lookups) issue no reads.
// One request is in flight at a time; req_stall is high from accept until
// its result moves into the output register, which then holds it while the
// receiver stalls, so the next request can already be taken.
// Reset empties the table at once (fill count to zero); no clearing pass.
module address_region_table #(
  parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  art_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output art_pkg::rsp_t rsp
);

  art_pkg::cmd_t  cmd;
  art_pkg::stat_t stat;

  art_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  art_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the address region table: directed, full and random requests.
module tb;

  localparam int DEPTH = art_pkg::ENTRIES_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  art_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  art_pkg::rsp_t rsp;

  // Regions as the testbench expects the block to hold them, oldest first
  logic [63:0] known_base [DEPTH];
  logic [31:0] known_len [DEPTH];
  logic [15:0] known_tag [DEPTH];
  int known_count = 0;

  art_pkg::rsp_t awaited_results [$];
  int mismatches = 0;
  bit no_idle = 1'b0;
  int rsp_hold = 0;

  address_region_table #(.ENTRIES(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Apply one request to the expected table and work out its result
  function automatic art_pkg::rsp_t resolve_request(input art_pkg::req_t r);
    art_pkg::rsp_t res;
    res = '0;
    case (r.req_type)
      art_pkg::REQ_INSERT: begin
        if (!r.kernel_image || r.name_tag == '0) begin
          res.status = art_pkg::ST_IGNORED;
        end else if (known_count >= DEPTH) begin
          res.status = art_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < known_count; i++) begin
            if (known_base[i] == r.address) res.status = art_pkg::ST_DUP;
          end
          if (res.status == art_pkg::ST_DONE) begin
            known_base[known_count] = r.address;
            known_len[known_count] = r.region_size;
            known_tag[known_count] = r.name_tag;
            known_count++;
          end
        end
      end
      art_pkg::REQ_LOOKUP: begin
        res.last_frame = r.last_address;
        res.offset = r.address;
        if (r.address != '0) begin
          // newest region first; the first one that contains the address wins
          for (int i = known_count - 1; i >= 0; i--) begin
            if (!res.found && r.address >= known_base[i] &&
                r.address - known_base[i] < {32'b0, known_len[i]}) begin
              res.found = 1'b1;
              res.result_tag = known_tag[i];
              res.offset = r.address - known_base[i];
            end
          end
        end
      end
      art_pkg::REQ_CLEAR: begin
        known_count = 0;
      end
      default: begin
        res.status = art_pkg::ST_IGNORED;
      end
    endcase
    return res;
  endfunction

  function automatic art_pkg::req_t make_req(input logic [1:0] kind,
                                             input logic [63:0] addr,
                                             input logic [31:0] len, input logic [15:0] tag,
                                             input logic kern, input logic last);
    art_pkg::req_t r;
    r.req_type = kind;
    r.address = addr;
    r.region_size = len;
    r.name_tag = tag;
    r.kernel_image = kern;
    r.last_address = last;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Present one request after a random gap and hold it until it is taken
  task automatic issue_request(input art_pkg::req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    awaited_results.push_back(resolve_request(r));
  endtask

  // Stall each result for a random number of its valid cycles
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_hold = no_idle ? 0 : $urandom_range(0, 8);
      rsp_stall <= (rsp_hold != 0);
    end else if (rsp_valid && rsp_stall) begin
      rsp_hold = rsp_hold - 1;
      rsp_stall <= (rsp_hold != 0);
    end
  end

  // Compare each result taken with the oldest outstanding expectation
  always @(posedge clk) begin : check_results
    art_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %h, want %h", rsp.status, want.status));
        if (rsp.found !== want.found)
          report_mismatch($sformatf("found %h, want %h", rsp.found, want.found));
        if (rsp.result_tag !== want.result_tag)
          report_mismatch($sformatf("tag %h, want %h", rsp.result_tag, want.result_tag));
        if (rsp.offset !== want.offset)
          report_mismatch($sformatf("offset %h, want %h", rsp.offset, want.offset));
        if (rsp.last_frame !== want.last_frame)
          report_mismatch($sformatf("last %h, want %h", rsp.last_frame, want.last_frame));
      end
    end
  end

  // Ignored inserts, duplicates, zero length, overlap, zero address, edges of the space
  task automatic test_directed_cases();
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h0, '1, '1, 1'b1, 1'b1));
    issue_request(make_req(art_pkg::REQ_LOOKUP, '1, 32'h0, 16'h0, 1'b0, 1'b0));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h1000, 32'h100, 16'hFFFF, 1'b0, 1'b1));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h1000, 32'h100, 16'h0000, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h1000, 32'h100, 16'hFFFF, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h1000, 32'h200, 16'h0042, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h5000, 32'h0, 16'h0001, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h5000, 32'h0, 16'h0, 1'b0, 1'b1));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h1080, 32'h1000, 16'h1234, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h10C0, 32'h0, 16'h0, 1'b0, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h1010, 32'h0, 16'h0, 1'b0, 1'b1));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h0FFF, 32'h0, 16'h0, 1'b0, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h207F, 32'h0, 16'h0, 1'b0, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h2080, 32'h0, 16'h0, 1'b0, 1'b1));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_F000, '1, 16'h8000,
                           1'b1, 1'b1));
    issue_request(make_req(art_pkg::REQ_LOOKUP, '1, 32'h0, 16'h0, 1'b0, 1'b0));
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h0, 32'h10, 16'h0007, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h0, 32'h0, 16'h0, 1'b0, 1'b1));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h8, 32'h0, 16'h0, 1'b0, 1'b0));
    issue_request(make_req(2'b11, '1, '1, '1, 1'b1, 1'b1));
    issue_request(make_req(art_pkg::REQ_CLEAR, '1, '1, '1, 1'b1, 1'b1));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h1010, 32'h0, 16'h0, 1'b0, 1'b0));
  endtask

  // Fill every entry, then check that full wins over duplicate and loses to ignore
  task automatic test_full_table();
    logic [63:0] base;
    logic [31:0] len;
    issue_request(make_req(art_pkg::REQ_CLEAR, '0, '0, '0, 1'b0, 1'b0));
    for (int i = 0; i < DEPTH; i++) begin
      base = {32'($urandom), 16'(i), 16'h0};
      len = $urandom_range(1, 32'h1_0000);
      issue_request(make_req(art_pkg::REQ_INSERT, base, len,
                             16'($urandom_range(1, 16'hFFFF)), 1'b1, 1'($urandom)));
      if (i % 8 == 0)
        issue_request(make_req(art_pkg::REQ_LOOKUP, base + {32'b0, len} - 64'h1, '0, '0,
                               1'b0, 1'b1));
    end
    issue_request(make_req(art_pkg::REQ_INSERT, 64'h0123_0000_0000_0000, 32'h10, 16'h5A5A,
                           1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_INSERT, base, 32'h10, 16'h5A5A, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_INSERT, base, 32'h10, 16'h0000, 1'b1, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, base, '0, '0, 1'b0, 1'b0));
    issue_request(make_req(art_pkg::REQ_LOOKUP, 64'h0123_0000_0000_0008, '0, '0,
                           1'b0, 1'b1));
    issue_request(make_req(art_pkg::REQ_CLEAR, '0, '0, '0, 1'b0, 1'b0));
  endtask

  // Episodes that start from an empty table: inserts, lookups aimed at stored regions, noise
  task automatic test_random_traffic(input int count);
    art_pkg::req_t r;
    int pick;
    int way;
    int idx;
    int sent;
    int episode_len;
    sent = 0;
    while (sent < count) begin
      episode_len = $urandom_range(10, 160);
      no_idle = ($urandom_range(0, 4) == 0);
      issue_request(make_req(art_pkg::REQ_CLEAR, {$urandom, $urandom}, $urandom,
                             16'($urandom), 1'($urandom), 1'($urandom)));
      sent++;
      repeat (episode_len) begin
        pick = $urandom_range(0, 99);
        way = $urandom_range(0, 9);
        r = make_req(art_pkg::REQ_LOOKUP, {$urandom, $urandom}, $urandom, 16'($urandom),
                     1'($urandom), 1'($urandom));
        if (pick < 45) begin
          r.req_type = art_pkg::REQ_INSERT;
          r.kernel_image = ($urandom_range(0, 9) != 0);
          if ($urandom_range(0, 9) == 0) r.name_tag = '0;
          else if (r.name_tag == '0) r.name_tag = 16'h0001;
          // bases: a crowded window for overlaps, stored bases for duplicates, top of space
          if (way < 3) r.address = 64'h0000_7FF0_0000_0000 | 64'(20'($urandom));
          else if (way < 5 && known_count > 0)
            r.address = known_base[$urandom_range(0, known_count - 1)];
          else if (way == 5) r.address = {32'hFFFF_FFFF, $urandom};
          way = $urandom_range(0, 9);
          if (way == 0) r.region_size = '0;
          else if (way > 1) r.region_size = $urandom_range(1, 32'h4000);
        end else if (pick < 94) begin
          if (way < 6 && known_count > 0) begin
            idx = $urandom_range(0, known_count - 1);
            r.address = known_base[idx];
            if (known_len[idx] != '0) r.address += 64'($urandom % known_len[idx]);
          end else if (way == 6 && known_count > 0) begin
            idx = $urandom_range(0, known_count - 1);
            r.address = known_base[idx] + {32'b0, known_len[idx]};
          end else if (way == 7) begin
            r.address = '0;
          end else if (way == 8) begin
            r.address = 64'h0000_7FF0_0000_0000 | 64'(20'($urandom));
          end
        end else if (pick < 97) begin
          r.req_type = art_pkg::REQ_CLEAR;
        end else begin
          r.req_type = 2'b11;
        end
        issue_request(r);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_table();
    test_random_traffic(1300);
    // Let the last results drain
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #(8_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
